### src/ohlcv_bar_resampler_defines.svh
// ----------------------------------------------------------------------------
// OHLCV bar resampler assertion macros
// Shared concurrent assertion forms for the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef OHLCV_BAR_RESAMPLER_DEFINES_SVH
`define OHLCV_BAR_RESAMPLER_DEFINES_SVH

// same-cycle implication
`define OHLCV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ohlcv assertion failed");

// next-cycle implication
`define OHLCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ohlcv assertion failed");

`endif

### src/ohlcv_pkg.sv
// ----------------------------------------------------------------------------
// OHLCV package
// Field widths, transaction types and state encodings for the resampler.
// ----------------------------------------------------------------------------
package ohlcv_pkg;

   localparam int TIME_W   = 40;
   localparam int PRICE_W  = 32;
   localparam int VOL_IN_W = 32;
   localparam int VOL_W    = 48;
   localparam int IV_W     = 17;

   localparam logic [IV_W-1:0] INTERVAL_RESET = 17'd300;

   localparam logic OP_BAR   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic               op;
      logic [TIME_W-1:0]  bar_time;
      logic [PRICE_W-1:0] open_price;
      logic [PRICE_W-1:0] high_price;
      logic [PRICE_W-1:0] low_price;
      logic [PRICE_W-1:0] close_price;
      logic [VOL_IN_W-1:0] volume;
   } req_item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  bucket_time;
      logic [PRICE_W-1:0] out_open;
      logic [PRICE_W-1:0] out_high;
      logic [PRICE_W-1:0] out_low;
      logic [PRICE_W-1:0] out_close;
      logic [VOL_W-1:0]   out_volume;
      logic               from_flush;
   } rsp_item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  bucket;
      logic [PRICE_W-1:0] open_p;
      logic [PRICE_W-1:0] high_p;
      logic [PRICE_W-1:0] low_p;
      logic [PRICE_W-1:0] close_p;
      logic [VOL_W-1:0]   vol;
   } agg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE
   } state_type;

endpackage

### src/ohlcv_bucket_unit.sv
// ----------------------------------------------------------------------------
// OHLCV bucket unit
// Bit-serial restoring remainder of time by interval, one time bit per cycle;
// bucket start = time - (time mod interval).
// ----------------------------------------------------------------------------
module ohlcv_bucket_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ohlcv_pkg::TIME_W-1:0]  time_value,
   input  logic [ohlcv_pkg::IV_W-1:0]    interval,
   output logic                          done,
   output logic [ohlcv_pkg::TIME_W-1:0]  bucket
);

   localparam int CNT_W = $clog2(ohlcv_pkg::TIME_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ohlcv_pkg::TIME_W - 1);

   logic                         busy_ff,  busy_in;
   logic                         done_ff,  done_in;
   logic [CNT_W-1:0]             cnt_ff,   cnt_in;
   logic [ohlcv_pkg::TIME_W-1:0] time_ff,  time_in;
   logic [ohlcv_pkg::TIME_W-1:0] shift_ff, shift_in;
   logic [ohlcv_pkg::IV_W-1:0]   rem_ff,   rem_in;

   logic [ohlcv_pkg::IV_W:0]     partial;
   logic [ohlcv_pkg::IV_W:0]     diff;
   logic                         fits;

   always_comb begin
      partial = {rem_ff, shift_ff[ohlcv_pkg::TIME_W-1]};
      diff    = partial - {1'b0, interval};
      fits    = partial >= {1'b0, interval};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      time_in  = time_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         time_in  = time_value;
         shift_in = time_value;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[ohlcv_pkg::IV_W-1:0] : partial[ohlcv_pkg::IV_W-1:0];
         shift_in = {shift_ff[ohlcv_pkg::TIME_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      time_ff  <= time_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = time_ff - {(ohlcv_pkg::TIME_W - ohlcv_pkg::IV_W)'(0), rem_ff};

endmodule

### src/ohlcv_bar_resampler.sv
// ----------------------------------------------------------------------------
// OHLCV bar resampler
// Merges time-ordered OHLCV bars into coarser time buckets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   ohlcv_pkg::req_item_type
//  rsp      out        rsp_valid/rsp_stall   ohlcv_pkg::rsp_item_type
//  csr      in         csr_wr_en             interval_seconds, 17 bits
//
//  A bar passes through accept, 40 bucket-unit steps (one time bit each),
//  bucket capture and merge. A flush passes through accept and merge.
//  Reset clears the pending bar and loads an interval of 300 s.
//  The merge cycle waits while it has a bar to emit and rsp holds one stalled.
//  req_stall is high from accept until the merge cycle completes.
// ----------------------------------------------------------------------------
`include "ohlcv_bar_resampler_defines.svh"

module ohlcv_bar_resampler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ohlcv_pkg::req_item_type     req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ohlcv_pkg::rsp_item_type     rsp_item,
   input  logic                        csr_wr_en,
   input  logic [ohlcv_pkg::IV_W-1:0]  csr_wr_data
);

   ohlcv_pkg::state_type           state_ff, state_in;
   ohlcv_pkg::req_item_type        item_ff, item_in;
   logic [ohlcv_pkg::TIME_W-1:0]   bucket_ff, bucket_in;
   logic                           have_bar_ff, have_bar_in;
   ohlcv_pkg::agg_type             agg_ff, agg_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ohlcv_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;
   logic [ohlcv_pkg::IV_W-1:0]     interval_ff;

   logic [ohlcv_pkg::IV_W-1:0]     interval_eff;
   logic                           div_start;
   logic                           div_done;
   logic [ohlcv_pkg::TIME_W-1:0]   div_bucket;
   logic                           is_flush;
   logic                           emit;
   logic                           blocked;
   logic [ohlcv_pkg::VOL_W:0]      vol_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= ohlcv_pkg::INTERVAL_RESET;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   assign interval_eff = (interval_ff == '0) ? ohlcv_pkg::IV_W'(1) : interval_ff;

   ohlcv_bucket_unit u_bucket (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .time_value (req_item.bar_time),
      .interval   (interval_eff),
      .done       (div_done),
      .bucket     (div_bucket)
   );

   always_comb begin
      is_flush = item_ff.op == ohlcv_pkg::OP_FLUSH;
      emit     = have_bar_ff && (is_flush || (bucket_ff != agg_ff.bucket));
      blocked  = emit && rsp_valid_ff && rsp_stall;
      vol_sum  = {1'b0, agg_ff.vol}
               + {(ohlcv_pkg::VOL_W + 1 - ohlcv_pkg::VOL_IN_W)'(0), item_ff.volume};

      state_in     = state_ff;
      item_in      = item_ff;
      bucket_in    = bucket_ff;
      have_bar_in  = have_bar_ff;
      agg_in       = agg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      div_start    = 1'b0;
      req_stall    = 1'b1;

      case (state_ff)
         ohlcv_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in = req_item;
               if (req_item.op == ohlcv_pkg::OP_FLUSH) begin
                  state_in = ohlcv_pkg::ST_UPDATE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ohlcv_pkg::ST_DIVIDE;
               end
            end
         end
         ohlcv_pkg::ST_DIVIDE: begin
            if (div_done) begin
               bucket_in = div_bucket;
               state_in  = ohlcv_pkg::ST_UPDATE;
            end
         end
         ohlcv_pkg::ST_UPDATE: begin
            if (!blocked) begin
               state_in = ohlcv_pkg::ST_IDLE;
               if (emit) begin
                  rsp_valid_in            = 1'b1;
                  rsp_item_in.bucket_time = agg_ff.bucket;
                  rsp_item_in.out_open    = agg_ff.open_p;
                  rsp_item_in.out_high    = agg_ff.high_p;
                  rsp_item_in.out_low     = agg_ff.low_p;
                  rsp_item_in.out_close   = agg_ff.close_p;
                  rsp_item_in.out_volume  = agg_ff.vol;
                  rsp_item_in.from_flush  = is_flush;
               end
               if (is_flush) begin
                  have_bar_in = 1'b0;
               end else if (!have_bar_ff || emit) begin
                  have_bar_in    = 1'b1;
                  agg_in.bucket  = bucket_ff;
                  agg_in.open_p  = item_ff.open_price;
                  agg_in.high_p  = item_ff.high_price;
                  agg_in.low_p   = item_ff.low_price;
                  agg_in.close_p = item_ff.close_price;
                  agg_in.vol     = {(ohlcv_pkg::VOL_W - ohlcv_pkg::VOL_IN_W)'(0),
                                    item_ff.volume};
               end else begin
                  if (item_ff.high_price > agg_ff.high_p) begin
                     agg_in.high_p = item_ff.high_price;
                  end
                  if (item_ff.low_price < agg_ff.low_p) begin
                     agg_in.low_p = item_ff.low_price;
                  end
                  agg_in.close_p = item_ff.close_price;
                  agg_in.vol     = vol_sum[ohlcv_pkg::VOL_W] ? '1
                                                             : vol_sum[ohlcv_pkg::VOL_W-1:0];
               end
            end
         end
         default: begin
            state_in = ohlcv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ohlcv_pkg::ST_IDLE;
         have_bar_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_bar_ff  <= have_bar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      bucket_ff   <= bucket_in;
      agg_ff      <= agg_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `OHLCV_ASSERT_NEXT(a_divide_to_update, clock, reset, (state_ff == ohlcv_pkg::ST_DIVIDE) && div_done, state_ff == ohlcv_pkg::ST_UPDATE)
   `OHLCV_ASSERT_NEXT(a_flush_clears_bar, clock, reset, (state_ff == ohlcv_pkg::ST_UPDATE) && is_flush && !blocked, !have_bar_ff)
   `OHLCV_ASSERT_NOW(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ohlcv_pkg::ST_UPDATE)

endmodule
